### rtl/plq_pkg.sv
package plq_pkg;

  // table geometry
  localparam int unsigned MaxOrders  = 1024;
  localparam int unsigned SlotAw     = $clog2(MaxOrders);
  localparam int unsigned LinkW      = 11;
  localparam int unsigned OrderSlotW = 10;
  localparam int unsigned PriceW     = 32;
  localparam int unsigned QtyW       = 64;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned StatusW    = 3;

  // link value that marks no order
  localparam logic [LinkW-1:0] NoneSlot = LinkW'(MaxOrders);

  // command codes
  localparam logic [CmdW-1:0] CmdAdd    = 2'd0;
  localparam logic [CmdW-1:0] CmdRemove = 2'd1;
  localparam logic [CmdW-1:0] CmdReduce = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] StOk        = 3'd0;
  localparam logic [StatusW-1:0] StNull      = 3'd1;
  localparam logic [StatusW-1:0] StPrice     = 3'd2;
  localparam logic [StatusW-1:0] StMember    = 3'd3;
  localparam logic [StatusW-1:0] StFilled    = 3'd4;
  localparam logic [StatusW-1:0] StOverflow  = 3'd5;
  localparam logic [StatusW-1:0] StNotMember = 3'd6;
  localparam logic [StatusW-1:0] StBelowZero = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic clear_en;
    logic accept;
    logic exec;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } dp_status_t;

  // true when a link names a real slot
  function automatic logic link_ok(input logic [LinkW-1:0] s);
    return s < NoneSlot;
  endfunction

endpackage

### rtl/plq_ram.sv
module plq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/plq_ctrl.sv
module plq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  plq_pkg::dp_status_t    status_i,
  output plq_pkg::ctrl_cmd_t     ctrl_o,
  output logic                   busy_o,
  output logic                   done_o
);
  import plq_pkg::*;

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StExec  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done_q;
  logic       accept;

  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (status_i.clear_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StExec);
    end
  end

  assign ctrl_o.clear_en = (state_q == StClear);
  assign ctrl_o.accept   = accept;
  assign ctrl_o.exec     = (state_q == StExec);
  assign done_o          = done_q;

endmodule

### rtl/plq_dp.sv
module plq_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  plq_pkg::ctrl_cmd_t                ctrl_i,
  output plq_pkg::dp_status_t               status_o,
  input  logic                              cfg_we_i,
  input  logic [plq_pkg::PriceW-1:0]        cfg_wdata_i,
  input  logic [plq_pkg::CmdW-1:0]          cmd_i,
  input  logic                              has_order_i,
  input  logic [plq_pkg::OrderSlotW-1:0]    order_slot_i,
  input  logic [plq_pkg::PriceW-1:0]        order_price_i,
  input  logic [plq_pkg::QtyW-1:0]          quantity_i,
  output logic [plq_pkg::StatusW-1:0]       status_res_o,
  output logic [plq_pkg::LinkW-1:0]         head_slot_o,
  output logic [plq_pkg::LinkW-1:0]         tail_slot_o,
  output logic [plq_pkg::LinkW-1:0]         order_count_o,
  output logic [plq_pkg::QtyW-1:0]          total_quantity_o,
  output logic                              empty_res_o
);
  import plq_pkg::*;

  // configuration and latched command
  logic [PriceW-1:0]     level_price_q;
  logic [CmdW-1:0]       cmd_q;
  logic                  has_q;
  logic [OrderSlotW-1:0] slot_q;
  logic [PriceW-1:0]     price_q;
  logic [QtyW-1:0]       qty_q;

  // level state
  logic [LinkW-1:0] head_q, head_d;
  logic [LinkW-1:0] tail_q, tail_d;
  logic [LinkW-1:0] count_q, count_d;
  logic [QtyW-1:0]  total_q, total_d;
  logic [StatusW-1:0] st_q, st_d;
  logic [SlotAw-1:0]  clr_cnt_q;

  // memory ports
  logic [SlotAw-1:0] rd_addr;
  logic [LinkW-1:0]  next_rd, prev_rd;
  logic              member_rd;
  logic              next_we, prev_we, mem_we;
  logic [SlotAw-1:0] next_waddr, prev_waddr, mem_waddr;
  logic [LinkW-1:0]  next_wdata, prev_wdata;
  logic              mem_wdata;
  logic              next_upd, prev_upd, mem_upd;
  logic [SlotAw-1:0] next_addr_e, prev_addr_e;
  logic [LinkW-1:0]  next_data_e, prev_data_e;
  logic              mem_data_e;

  // derived values
  logic [LinkW-1:0] slot_link;
  logic             slot_in;
  logic [LinkW-1:0] p_link, n_link;
  logic [QtyW:0]    sum_w, diff_w;

  assign rd_addr   = SlotAw'(order_slot_i);
  assign slot_link = LinkW'(slot_q);
  assign slot_in   = link_ok(slot_link);

  // head has no predecessor, tail has no successor
  assign p_link = (slot_link == head_q) ? NoneSlot : prev_rd;
  assign n_link = (slot_link == tail_q) ? NoneSlot : next_rd;

  assign sum_w  = {1'b0, total_q} + {1'b0, qty_q};
  assign diff_w = {1'b0, total_q} - {1'b0, qty_q};

  // command decode and checks
  always_comb begin
    st_d        = StOk;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    total_d     = total_q;
    next_upd    = 1'b0;
    prev_upd    = 1'b0;
    mem_upd     = 1'b0;
    next_addr_e = SlotAw'(slot_q);
    prev_addr_e = SlotAw'(slot_q);
    next_data_e = NoneSlot;
    prev_data_e = NoneSlot;
    mem_data_e  = 1'b0;
    case (cmd_q)
      CmdAdd: begin
        if (!has_q || !slot_in) begin
          st_d = StNull;
        end else if (price_q != level_price_q) begin
          st_d = StPrice;
        end else if (member_rd) begin
          st_d = StMember;
        end else if (qty_q == '0) begin
          st_d = StFilled;
        end else if (sum_w[QtyW]) begin
          st_d = StOverflow;
        end else begin
          prev_upd    = 1'b1;
          prev_addr_e = SlotAw'(slot_q);
          prev_data_e = tail_q;
          if (link_ok(tail_q)) begin
            next_upd    = 1'b1;
            next_addr_e = tail_q[SlotAw-1:0];
            next_data_e = slot_link;
          end else begin
            head_d = slot_link;
          end
          tail_d     = slot_link;
          count_d    = count_q + LinkW'(1);
          total_d    = sum_w[QtyW-1:0];
          mem_upd    = 1'b1;
          mem_data_e = 1'b1;
        end
      end
      CmdRemove: begin
        if (!has_q || !slot_in || !member_rd) begin
          st_d = StNotMember;
        end else begin
          if (link_ok(p_link)) begin
            next_upd    = 1'b1;
            next_addr_e = p_link[SlotAw-1:0];
            next_data_e = n_link;
          end else begin
            head_d = link_ok(n_link) ? n_link : NoneSlot;
          end
          if (link_ok(n_link)) begin
            prev_upd    = 1'b1;
            prev_addr_e = n_link[SlotAw-1:0];
            prev_data_e = p_link;
          end else begin
            tail_d = link_ok(p_link) ? p_link : NoneSlot;
          end
          // remove saturates at zero
          total_d    = diff_w[QtyW] ? '0 : diff_w[QtyW-1:0];
          count_d    = (count_q != '0) ? count_q - LinkW'(1) : count_q;
          mem_upd    = 1'b1;
          mem_data_e = 1'b0;
        end
      end
      CmdReduce: begin
        if (diff_w[QtyW]) begin
          st_d = StBelowZero;
        end else begin
          total_d = diff_w[QtyW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // memory write ports, clearing sweep owns the member table after reset
  assign next_we    = ctrl_i.exec && next_upd;
  assign next_waddr = next_addr_e;
  assign next_wdata = next_data_e;
  assign prev_we    = ctrl_i.exec && prev_upd;
  assign prev_waddr = prev_addr_e;
  assign prev_wdata = prev_data_e;
  assign mem_we     = ctrl_i.clear_en || (ctrl_i.exec && mem_upd);
  assign mem_waddr  = ctrl_i.clear_en ? clr_cnt_q : SlotAw'(slot_q);
  assign mem_wdata  = ctrl_i.clear_en ? 1'b0 : mem_data_e;

  plq_ram #(
    .Width (LinkW),
    .Depth (MaxOrders)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (rd_addr),
    .rdata_o (next_rd)
  );

  plq_ram #(
    .Width (LinkW),
    .Depth (MaxOrders)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (rd_addr),
    .rdata_o (prev_rd)
  );

  plq_ram #(
    .Width (1),
    .Depth (MaxOrders)
  ) u_member_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_addr),
    .rdata_o (member_rd)
  );

  // command capture and status
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q   <= cmd_i;
      has_q   <= has_order_i;
      slot_q  <= order_slot_i;
      price_q <= order_price_i;
      qty_q   <= quantity_i;
    end
    if (ctrl_i.exec) begin
      st_q <= st_d;
    end
  end

  // level registers, clear counter and price register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= NoneSlot;
      tail_q        <= NoneSlot;
      count_q       <= '0;
      total_q       <= '0;
      clr_cnt_q     <= '0;
      level_price_q <= '0;
    end else begin
      if (ctrl_i.exec) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
        total_q <= total_d;
      end
      if (ctrl_i.clear_en) begin
        clr_cnt_q <= clr_cnt_q + SlotAw'(1);
      end
      if (cfg_we_i) begin
        level_price_q <= cfg_wdata_i;
      end
    end
  end

  assign status_o.clear_last = (clr_cnt_q == SlotAw'(MaxOrders - 1));

  assign status_res_o     = st_q;
  assign head_slot_o      = head_q;
  assign tail_slot_o      = tail_q;
  assign order_count_o    = count_q;
  assign total_quantity_o = total_q;
  assign empty_res_o      = (count_q == '0);

endmodule

### rtl/price_level_order_queue_core.sv
// a taken command runs in the exec state; its result strobe is registered from it
// busy blocks new commands; the link tables are read at the taking edge and
//   written in exec: add links the slot behind the tail, remove joins its neighbors
// reset: head and tail go to none, count and total to zero; then busy stays high
//   while the membership table is cleared one entry a cycle
// the result strobe lasts one cycle and the receiver cannot stall it
module price_level_order_queue_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [plq_pkg::PriceW-1:0]        cfg_wdata_i,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [plq_pkg::CmdW-1:0]          cmd_i,
  input  logic                              has_order_i,
  input  logic [plq_pkg::OrderSlotW-1:0]    order_slot_i,
  input  logic [plq_pkg::PriceW-1:0]        order_price_i,
  input  logic [plq_pkg::QtyW-1:0]          quantity_i,
  output logic                              result_valid_o,
  output logic [plq_pkg::StatusW-1:0]       status_o,
  output logic [plq_pkg::LinkW-1:0]         head_slot_o,
  output logic [plq_pkg::LinkW-1:0]         tail_slot_o,
  output logic [plq_pkg::LinkW-1:0]         order_count_o,
  output logic [plq_pkg::QtyW-1:0]          total_quantity_o,
  output logic                              empty_res_o
);
  import plq_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t dp_status;

  // sequencer
  plq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (dp_status),
    .ctrl_o   (ctrl),
    .busy_o   (busy_o),
    .done_o   (result_valid_o)
  );

  // link tables and level registers
  plq_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .status_o         (dp_status),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (cmd_i),
    .has_order_i      (has_order_i),
    .order_slot_i     (order_slot_i),
    .order_price_i    (order_price_i),
    .quantity_i       (quantity_i),
    .status_res_o     (status_o),
    .head_slot_o      (head_slot_o),
    .tail_slot_o      (tail_slot_o),
    .order_count_o    (order_count_o),
    .total_quantity_o (total_quantity_o),
    .empty_res_o      (empty_res_o)
  );

endmodule

### rtl/plq_checker.sv
module plq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          result_valid_o,
  input logic [plq_pkg::LinkW-1:0]     head_slot_o,
  input logic [plq_pkg::LinkW-1:0]     tail_slot_o,
  input logic [plq_pkg::LinkW-1:0]     order_count_o,
  input logic                          empty_res_o
);
  import plq_pkg::*;

  // every taken command is followed by a busy cycle and then a result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o ##1 result_valid_o)
    else $error("taken command gave no result beat");

  // a result beat only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result beat without a command in flight");

  // result beats never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // empty flag agrees with the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (empty_res_o == (order_count_o == '0)))
    else $error("empty flag disagrees with order count");

  // an empty level has no head and no tail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && empty_res_o) |-> (head_slot_o == NoneSlot && tail_slot_o == NoneSlot))
    else $error("empty level still points at an order");

endmodule

bind price_level_order_queue_core plq_checker u_plq_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import plq_pkg::*;

  // command code with no operation behind it
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam logic [QtyW-1:0] QtyMax    = '1;

  // one level snapshot as the block reports it
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [LinkW-1:0]   head;
    logic [LinkW-1:0]   tail;
    logic [LinkW-1:0]   count;
    logic [QtyW-1:0]    total;
    logic               empty;
  } level_snapshot_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [PriceW-1:0]     cfg_wdata_i;
  logic                  start_i;
  logic                  busy_o;
  logic [CmdW-1:0]       cmd_i;
  logic                  has_order_i;
  logic [OrderSlotW-1:0] order_slot_i;
  logic [PriceW-1:0]     order_price_i;
  logic [QtyW-1:0]       quantity_i;
  logic                  result_valid_o;
  logic [StatusW-1:0]    status_o;
  logic [LinkW-1:0]      head_slot_o;
  logic [LinkW-1:0]      tail_slot_o;
  logic [LinkW-1:0]      order_count_o;
  logic [QtyW-1:0]       total_quantity_o;
  logic                  empty_res_o;

  price_level_order_queue_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .cmd_i            (cmd_i),
    .has_order_i      (has_order_i),
    .order_slot_i     (order_slot_i),
    .order_price_i    (order_price_i),
    .quantity_i       (quantity_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .head_slot_o      (head_slot_o),
    .tail_slot_o      (tail_slot_o),
    .order_count_o    (order_count_o),
    .total_quantity_o (total_quantity_o),
    .empty_res_o      (empty_res_o)
  );

  // predicted level state
  logic [PriceW-1:0]  lvl_price;
  logic [LinkW-1:0]   lvl_next [MaxOrders];
  logic [LinkW-1:0]   lvl_prev [MaxOrders];
  bit                 lvl_member [MaxOrders];
  logic [LinkW-1:0]   lvl_head;
  logic [LinkW-1:0]   lvl_tail;
  logic [LinkW-1:0]   lvl_count;
  logic [QtyW-1:0]    lvl_total;
  logic [StatusW-1:0] last_status;

  level_snapshot_t level_results_q [$];
  level_snapshot_t oldest;
  int unsigned     mismatch_count;

  // stimulus bookkeeping: slots in play and the quantity each was added with
  logic [OrderSlotW-1:0] slot_pool [16];
  bit   [QtyW-1:0]       slot_qty [MaxOrders];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("price_level_order_queue_core: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [QtyW-1:0] got,
                                 input logic [QtyW-1:0] want);
    if (mismatch_count < 40) begin
      $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // apply one command to the predicted level and queue the snapshot after it
  task automatic level_apply(input logic [CmdW-1:0] cmd, input logic has,
                             input logic [OrderSlotW-1:0] slot,
                             input logic [PriceW-1:0] price, input logic [QtyW-1:0] qty);
    level_snapshot_t    snap;
    logic [LinkW-1:0]   p;
    logic [LinkW-1:0]   n;
    logic [StatusW-1:0] st;
    st = StOk;
    case (cmd)
      CmdAdd: begin
        if (!has) st = StNull;
        else if (price != lvl_price) st = StPrice;
        else if (lvl_member[slot]) st = StMember;
        else if (qty == '0) st = StFilled;
        else if (qty > ~lvl_total) st = StOverflow;
        else begin
          // append at the tail
          lvl_prev[slot] = lvl_tail;
          lvl_next[slot] = NoneSlot;
          if (lvl_tail < NoneSlot) lvl_next[lvl_tail[SlotAw-1:0]] = LinkW'(slot);
          else lvl_head = LinkW'(slot);
          lvl_tail = LinkW'(slot);
          lvl_count++;
          lvl_total += qty;
          lvl_member[slot] = 1'b1;
        end
      end
      CmdRemove: begin
        if (!has || !lvl_member[slot]) st = StNotMember;
        else begin
          // unlink from any position, total saturates at zero
          p = lvl_prev[slot];
          n = lvl_next[slot];
          if (p < NoneSlot) lvl_next[p[SlotAw-1:0]] = n;
          else lvl_head = (n < NoneSlot) ? n : NoneSlot;
          if (n < NoneSlot) lvl_prev[n[SlotAw-1:0]] = p;
          else lvl_tail = (p < NoneSlot) ? p : NoneSlot;
          lvl_total = (lvl_total >= qty) ? lvl_total - qty : '0;
          if (lvl_count > 0) lvl_count--;
          lvl_prev[slot] = NoneSlot;
          lvl_next[slot] = NoneSlot;
          lvl_member[slot] = 1'b0;
        end
      end
      CmdReduce: begin
        if (qty > lvl_total) st = StBelowZero;
        else lvl_total -= qty;
      end
      default: st = StOk;
    endcase
    snap.status = st;
    snap.head   = lvl_head;
    snap.tail   = lvl_tail;
    snap.count  = lvl_count;
    snap.total  = lvl_total;
    snap.empty  = (lvl_count == 0);
    last_status = st;
    level_results_q.push_back(snap);
  endtask

  // drive one command and hold it until the block takes it
  task automatic send_command(input logic [CmdW-1:0] cmd, input logic has,
                              input logic [OrderSlotW-1:0] slot,
                              input logic [PriceW-1:0] price, input logic [QtyW-1:0] qty);
    start_i       <= 1'b1;
    cmd_i         <= cmd;
    has_order_i   <= has;
    order_slot_i  <= slot;
    order_price_i <= price;
    quantity_i    <= qty;
    do @(posedge clk_i); while (busy_o);
    level_apply(cmd, has, slot, price, qty);
  endtask

  task automatic idle_for(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // wait until every result is in and the block is idle
  task automatic drain_level();
    start_i <= 1'b0;
    @(posedge clk_i);
    for (int i = 0; i < 200 && (level_results_q.size() != 0 || busy_o); i++) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_level_price(input logic [PriceW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lvl_price = value;
  endtask

  task automatic fill_slot_pool(input bit with_ends);
    foreach (slot_pool[i]) slot_pool[i] = OrderSlotW'($urandom_range(0, MaxOrders - 1));
    if (with_ends) begin
      slot_pool[0] = '0;
      slot_pool[1] = '1;
    end
  endtask

  // one random command, mostly well formed against the current level
  task automatic random_command();
    logic [CmdW-1:0]       cmd;
    logic                  has;
    logic [OrderSlotW-1:0] slot;
    logic [PriceW-1:0]     price;
    logic [QtyW-1:0]       qty;
    int unsigned           roll;
    roll  = $urandom_range(0, 99);
    has   = ($urandom_range(0, 19) != 0);
    slot  = slot_pool[$urandom_range(0, 15)];
    price = lvl_price;
    qty   = {$urandom, $urandom};
    if (roll < 45) begin
      cmd = CmdAdd;
      if ($urandom_range(0, 9) == 0) price = $urandom;
      case ($urandom_range(0, 19))
        0: qty = '0;
        1: qty = ~lvl_total;
        2: qty = ~lvl_total + 64'd1;
        3, 4, 5: qty = qty >> $urandom_range(0, 63);
        default: qty = QtyW'($urandom_range(1, 1000));
      endcase
    end else if (roll < 80) begin
      cmd = CmdRemove;
      // prefer a slot that is in the level
      for (int k = 0; k < 3 && !lvl_member[slot]; k++) begin
        slot = slot_pool[$urandom_range(0, 15)];
      end
      if ($urandom_range(0, 4) != 0) qty = slot_qty[slot];
    end else if (roll < 95) begin
      cmd = CmdReduce;
      case ($urandom_range(0, 9))
        0, 1: qty = lvl_total;
        2: qty = lvl_total + 64'd1;
        3: qty = qty;
        default: qty = QtyW'($urandom_range(0, 50));
      endcase
    end else begin
      cmd = CmdUnused;
    end
    send_command(cmd, has, slot, price, qty);
    if (cmd == CmdAdd && last_status == StOk) slot_qty[slot] = qty;
  endtask

  // add checks in order, then fill up to the top of the total
  task automatic test_add_checks();
    write_level_price(32'hFFFF_FFFF);
    send_command(CmdAdd, 1'b0, 10'd0,    32'hFFFF_FFFF, 64'd5);
    send_command(CmdAdd, 1'b1, 10'd0,    32'h0,         64'd5);
    send_command(CmdAdd, 1'b1, 10'd0,    32'hFFFF_FFFF, 64'd0);
    send_command(CmdAdd, 1'b1, 10'd0,    32'hFFFF_FFFF, 64'd5);
    send_command(CmdAdd, 1'b1, 10'd0,    32'hFFFF_FFFF, 64'd7);
    send_command(CmdAdd, 1'b1, 10'd1023, 32'hFFFF_FFFF, QtyMax - 64'd5);
    send_command(CmdAdd, 1'b1, 10'd512,  32'hFFFF_FFFF, 64'd1);
  endtask

  // fills: whole total, below zero, zero fill
  task automatic test_reduce();
    send_command(CmdReduce, 1'b1, 10'd0, 32'h0, QtyMax);
    send_command(CmdReduce, 1'b0, 10'd3, 32'h1234_5678, 64'd1);
    send_command(CmdReduce, 1'b1, 10'd0, 32'h0, 64'd0);
  endtask

  // unlink middle, head, only entry and tail; null and non-member removes
  task automatic test_remove();
    send_command(CmdAdd,    1'b1, 10'd512,  32'hFFFF_FFFF, 64'd10);
    send_command(CmdRemove, 1'b1, 10'd1023, 32'h0,         64'd3);
    send_command(CmdRemove, 1'b1, 10'd0,    32'h0,         64'd100);
    send_command(CmdRemove, 1'b1, 10'd0,    32'h0,         64'd1);
    send_command(CmdRemove, 1'b0, 10'd512,  32'h0,         64'd1);
    send_command(CmdRemove, 1'b1, 10'd512,  32'h0,         64'd0);
    send_command(CmdAdd,    1'b1, 10'd7,    32'hFFFF_FFFF, 64'd9);
    send_command(CmdAdd,    1'b1, 10'd8,    32'hFFFF_FFFF, 64'd1);
    send_command(CmdRemove, 1'b1, 10'd8,    32'h0,         64'd1);
    send_command(CmdRemove, 1'b1, 10'd7,    32'h0,         64'd9);
  endtask

  task automatic test_unused_cmd();
    send_command(CmdUnused, 1'b1, 10'd300, $urandom, {$urandom, $urandom});
  endtask

  // random traffic under several level prices, with bursty sender gaps
  task automatic test_random_levels();
    logic [PriceW-1:0] prices [5];
    bit                gaps_on;
    prices  = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 32'h0};
    gaps_on = 1'b1;
    prices[4] = $urandom;
    foreach (prices[p]) begin
      drain_level();
      write_level_price(prices[p]);
      fill_slot_pool(p == 0);
      for (int n = 0; n < 80; n++) begin
        random_command();
        if (gaps_on && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 14));
        if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
      end
    end
  endtask

  // back-to-back commands, no gaps
  task automatic test_streaming();
    fill_slot_pool(1'b0);
    for (int n = 0; n < 100; n++) random_command();
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (level_results_q.size() == 0) begin
        report_mismatch("result with nothing expected, status", QtyW'(status_o), '0);
      end else begin
        oldest = level_results_q.pop_front();
        if (status_o !== oldest.status)
          report_mismatch("status", QtyW'(status_o), QtyW'(oldest.status));
        if (head_slot_o !== oldest.head)
          report_mismatch("head_slot", QtyW'(head_slot_o), QtyW'(oldest.head));
        if (tail_slot_o !== oldest.tail)
          report_mismatch("tail_slot", QtyW'(tail_slot_o), QtyW'(oldest.tail));
        if (order_count_o !== oldest.count)
          report_mismatch("order_count", QtyW'(order_count_o), QtyW'(oldest.count));
        if (total_quantity_o !== oldest.total)
          report_mismatch("total_quantity", total_quantity_o, oldest.total);
        if (empty_res_o !== oldest.empty)
          report_mismatch("empty_res", QtyW'(empty_res_o), QtyW'(oldest.empty));
      end
    end
  end

  // main sequence
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    start_i        = 1'b0;
    cmd_i          = CmdAdd;
    has_order_i    = 1'b0;
    order_slot_i   = '0;
    order_price_i  = '0;
    quantity_i     = '0;
    mismatch_count = 0;
    lvl_price      = '0;
    lvl_head       = NoneSlot;
    lvl_tail       = NoneSlot;
    lvl_count      = '0;
    lvl_total      = '0;
    foreach (lvl_member[i]) lvl_member[i] = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // membership clear runs after reset
    do @(posedge clk_i); while (busy_o);

    test_add_checks();
    test_reduce();
    test_remove();
    test_unused_cmd();
    test_random_levels();
    test_streaming();

    drain_level();
    repeat (4) @(posedge clk_i);
    while (level_results_q.size() != 0) begin
      oldest = level_results_q.pop_front();
      report_mismatch("missing result, status", 'x, QtyW'(oldest.status));
    end

    if (mismatch_count == 0) begin
      $display("price_level_order_queue_core: match");
    end else begin
      $display("price_level_order_queue_core: mismatch");
    end
    $finish;
  end

endmodule
